/* hdl/i2crm_pkg.sv */
// ----------------------------------------------------------------------------
// i2crm_pkg
// Shared types and constants of the I2C register master.
// ----------------------------------------------------------------------------
package i2crm_pkg;

  localparam int unsigned MAX_BLOCK_DEF = 32;

  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_DEV_ADDR = 2'd0;
  localparam logic [1:0] REG_QTR_TICKS = 2'd1;
  localparam logic [1:0] REG_ACK_TMO = 2'd2;
  localparam logic [1:0] REG_ATT_LIMIT = 2'd3;

  localparam logic [6:0] DEV_ADDR_RST = 7'd104;
  localparam logic [15:0] QTR_TICKS_RST = 16'd10;
  localparam logic [7:0] ACK_TMO_RST = 8'd100;
  localparam logic [3:0] ATT_LIMIT_RST = 4'd5;

  // request codes
  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;
  localparam logic [1:0] FUNC_BLOCK = 2'd3;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_START    = 4'd1,
    PH_RSTART   = 4'd2,
    PH_TX       = 4'd3,
    PH_ACK_LOW  = 4'd4,
    PH_ACK_WAIT = 4'd5,
    PH_ACK_OK   = 4'd6,
    PH_ACK_NACK = 4'd7,
    PH_RX       = 4'd8,
    PH_MACK     = 4'd9,
    PH_STOP     = 4'd10
  } phase_e;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] reg_addr;
    logic [7:0] wr_data;
    logic [5:0] byte_count;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_low;
    logic       sda_low;
    logic [7:0] rd_data;
    logic       rd_valid;
    logic       last;
    logic       busy_res;
    logic       done_res;
    logic       status;
  } out_item_t;

  typedef struct packed {
    logic [6:0]  device_address;
    logic [15:0] quarter_period_ticks;
    logic [7:0]  ack_timeout;
    logic [3:0]  attempt_limit;
  } cfg_t;

endpackage

/* hdl/i2crm_core.sv */
// ----------------------------------------------------------------------------
// i2crm_core
// Bus sequencer: advances one tick per step and forms that tick's result.
// ----------------------------------------------------------------------------
module i2crm_core #(
  parameter int unsigned MAX_BLOCK = i2crm_pkg::MAX_BLOCK_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  i2crm_pkg::in_item_t  item_i,
  input  i2crm_pkg::cfg_t      cfg_i,
  output i2crm_pkg::out_item_t res_o
);
  import i2crm_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_BLOCK + 1);
  localparam int unsigned BI_W = CNT_W + 1;

  phase_e           phase_q, phase_d;
  logic [15:0]      td_q, td_d;
  logic [1:0]       quarter_q, quarter_d;
  logic [2:0]       bit_q, bit_d;
  logic [BI_W-1:0]  byte_q, byte_d;
  logic [7:0]       shift_q, shift_d;
  logic [7:0]       ackw_q, ackw_d;
  logic [3:0]       att_q, att_d;
  logic [1:0]       kind_q, kind_d;
  logic [7:0]       hreg_q, hreg_d;
  logic [7:0]       hdata_q, hdata_d;
  logic [CNT_W-1:0] hcnt_q, hcnt_d;
  logic [1:0]       hdr_q, hdr_d;
  logic             failed_q, failed_d;

  logic [15:0]      td_inc, qlen, td_qe;
  logic             qe;
  logic [1:0]       q_inc, hdr_inc;
  logic [7:0]       aw_inc;
  logic [3:0]       att_inc;
  logic [BI_W-1:0]  pair_len, last_pair, last_first;
  logic             last_bus;
  logic [5:0]       n_raw;
  logic             ev_valid, ev_last, ev_done, ev_fail;
  logic [7:0]       ev_data;

  assign qlen     = (cfg_i.quarter_period_ticks == 16'd0) ? 16'd1 : cfg_i.quarter_period_ticks;
  assign td_inc   = td_q + 16'd1;
  assign qe       = (td_inc >= qlen) || (td_inc == 16'd0);
  assign td_qe    = qe ? 16'd0 : td_inc;
  assign q_inc    = quarter_q + 2'd1;
  assign hdr_inc  = hdr_q + 2'd1;
  assign aw_inc   = (ackw_q != 8'hFF) ? ackw_q + 8'd1 : ackw_q;
  assign att_inc  = att_q + 4'd1;
  assign pair_len = {hcnt_q, 1'b0};
  assign last_pair  = pair_len - BI_W'(1);
  assign last_first = pair_len - BI_W'(2);
  assign last_bus = (kind_q != FUNC_BLOCK) || (byte_q == last_pair);
  assign n_raw    = item_i.byte_count;

  // next state
  always_comb begin
    phase_d   = phase_q;
    td_d      = td_q;
    quarter_d = quarter_q;
    bit_d     = bit_q;
    byte_d    = byte_q;
    shift_d   = shift_q;
    ackw_d    = ackw_q;
    att_d     = att_q;
    kind_d    = kind_q;
    hreg_d    = hreg_q;
    hdata_d   = hdata_q;
    hcnt_d    = hcnt_q;
    hdr_d     = hdr_q;
    failed_d  = failed_q;
    ev_valid  = 1'b0;
    ev_last   = 1'b0;
    ev_done   = 1'b0;
    ev_fail   = 1'b0;
    ev_data   = 8'd0;
    if (step_i) begin
      case (phase_q)
        PH_IDLE: begin
          if (item_i.func != FUNC_TICK) begin
            kind_d  = item_i.func;
            hreg_d  = item_i.reg_addr;
            hdata_d = item_i.wr_data;
            if (n_raw == 6'd0) begin
              hcnt_d = CNT_W'(1);
            end else if (32'(n_raw) > 32'(MAX_BLOCK)) begin
              hcnt_d = CNT_W'(MAX_BLOCK);
            end else begin
              hcnt_d = CNT_W'(n_raw);
            end
            att_d     = 4'd0;
            failed_d  = 1'b0;
            hdr_d     = 2'd0;
            phase_d   = PH_START;
            quarter_d = 2'd0;
            td_d      = 16'd0;
          end
        end
        PH_START: begin
          td_d = td_qe;
          if (qe) begin
            quarter_d = q_inc;
            if (quarter_q == 2'd3) begin
              shift_d = {cfg_i.device_address, (hdr_q != 2'd0)};
              bit_d   = 3'd0;
              phase_d = PH_TX;
            end
          end
        end
        PH_RSTART: begin
          td_d = td_qe;
          if (qe) begin
            phase_d   = PH_START;
            quarter_d = 2'd0;
          end
        end
        PH_TX: begin
          td_d = td_qe;
          if (qe) begin
            quarter_d = q_inc;
            if (quarter_q == 2'd3) begin
              shift_d = {shift_q[6:0], 1'b0};
              bit_d   = bit_q + 3'd1;
              if (bit_q == 3'd7) begin
                phase_d = PH_ACK_LOW;
              end
            end
          end
        end
        PH_ACK_LOW: begin
          td_d = td_qe;
          if (qe) begin
            quarter_d = q_inc;
            if (quarter_q == 2'd1) begin
              ackw_d    = 8'd0;
              phase_d   = PH_ACK_WAIT;
              quarter_d = 2'd0;
            end
          end
        end
        PH_ACK_WAIT: begin
          if (!item_i.sda_in) begin
            phase_d   = PH_ACK_OK;
            quarter_d = 2'd0;
            td_d      = 16'd0;
          end else begin
            ackw_d = aw_inc;
            if (aw_inc >= cfg_i.ack_timeout) begin
              phase_d   = PH_ACK_NACK;
              quarter_d = 2'd0;
              td_d      = 16'd0;
            end
          end
        end
        PH_ACK_OK, PH_ACK_NACK: begin
          td_d = td_qe;
          if (qe) begin
            quarter_d = 2'd0;
            if (phase_q == PH_ACK_NACK && kind_q == FUNC_WRITE) begin
              failed_d = 1'b1;
              phase_d  = PH_STOP;
            end else begin
              hdr_d = hdr_inc;
              if (hdr_inc == 2'd1) begin
                shift_d = hreg_q;
                bit_d   = 3'd0;
                phase_d = PH_TX;
              end else if (kind_q == FUNC_WRITE) begin
                if (hdr_inc == 2'd2) begin
                  shift_d = hdata_q;
                  bit_d   = 3'd0;
                  phase_d = PH_TX;
                end else begin
                  phase_d = PH_STOP;
                end
              end else if (hdr_inc == 2'd2) begin
                phase_d = PH_RSTART;
              end else begin
                byte_d  = '0;
                bit_d   = 3'd0;
                shift_d = 8'd0;
                phase_d = PH_RX;
              end
            end
          end
        end
        PH_RX: begin
          td_d = td_qe;
          if (qe) begin
            if (quarter_q == 2'd2) begin
              shift_d = {shift_q[6:0], item_i.sda_in};
            end
            quarter_d = q_inc;
            if (quarter_q == 2'd3) begin
              bit_d = bit_q + 3'd1;
              if (bit_q == 3'd7) begin
                if (kind_q != FUNC_BLOCK) begin
                  ev_valid = 1'b1;
                  ev_last  = 1'b1;
                  ev_data  = shift_q;
                end else if (!byte_q[0]) begin
                  ev_valid = 1'b1;
                  ev_data  = shift_q;
                  ev_last  = (byte_q == last_first);
                end
                phase_d = PH_MACK;
              end
            end
          end
        end
        PH_MACK: begin
          td_d = td_qe;
          if (qe) begin
            quarter_d = q_inc;
            if (quarter_q == 2'd3) begin
              if (last_bus) begin
                phase_d = PH_STOP;
              end else begin
                byte_d  = byte_q + BI_W'(1);
                bit_d   = 3'd0;
                shift_d = 8'd0;
                phase_d = PH_RX;
              end
            end
          end
        end
        PH_STOP: begin
          td_d = td_qe;
          if (qe) begin
            quarter_d = q_inc;
            if (quarter_q == 2'd3) begin
              if (failed_q) begin
                att_d = att_inc;
                if (att_inc >= cfg_i.attempt_limit) begin
                  phase_d = PH_IDLE;
                  ev_done = 1'b1;
                  ev_fail = 1'b1;
                end else begin
                  failed_d = 1'b0;
                  hdr_d    = 2'd0;
                  phase_d  = PH_START;
                end
              end else begin
                phase_d = PH_IDLE;
                ev_done = 1'b1;
              end
            end
          end
        end
        default: begin
          phase_d   = PH_IDLE;
          quarter_d = 2'd0;
          td_d      = 16'd0;
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    res_o = '0;
    case (phase_q)
      PH_START: begin
        res_o.scl_low = (quarter_q == 2'd3);
        res_o.sda_low = quarter_q[1];
      end
      PH_RSTART: res_o.scl_low = 1'b1;
      PH_TX: begin
        res_o.scl_low = !quarter_q[1];
        res_o.sda_low = !shift_q[7];
      end
      PH_ACK_LOW: res_o.scl_low = 1'b1;
      PH_RX: res_o.scl_low = !quarter_q[1];
      PH_MACK: begin
        res_o.scl_low = !quarter_q[1];
        res_o.sda_low = !last_bus;
      end
      PH_STOP: begin
        res_o.scl_low = (quarter_q == 2'd0);
        res_o.sda_low = !quarter_q[1];
      end
      default: begin
        res_o.scl_low = 1'b0;
        res_o.sda_low = 1'b0;
      end
    endcase
    res_o.rd_data  = ev_data;
    res_o.rd_valid = ev_valid;
    res_o.last     = ev_last;
    res_o.busy_res = (phase_d != PH_IDLE);
    res_o.done_res = ev_done;
    res_o.status   = ev_fail;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      td_q      <= '0;
      quarter_q <= '0;
      bit_q     <= '0;
      byte_q    <= '0;
      shift_q   <= '0;
      ackw_q    <= '0;
      att_q     <= '0;
      kind_q    <= '0;
      hreg_q    <= '0;
      hdata_q   <= '0;
      hcnt_q    <= '0;
      hdr_q     <= '0;
      failed_q  <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      td_q      <= td_d;
      quarter_q <= quarter_d;
      bit_q     <= bit_d;
      byte_q    <= byte_d;
      shift_q   <= shift_d;
      ackw_q    <= ackw_d;
      att_q     <= att_d;
      kind_q    <= kind_d;
      hreg_q    <= hreg_d;
      hdata_q   <= hdata_d;
      hcnt_q    <= hcnt_d;
      hdr_q     <= hdr_d;
      failed_q  <= failed_d;
    end
  end

endmodule

/* hdl/i2c_register_master_unit.sv */
// ----------------------------------------------------------------------------
// i2c_register_master_unit
// Open-drain I2C master for register writes, reads and paired block reads.
// ----------------------------------------------------------------------------
// Each request is one bus tick and yields exactly one result. One request is
// taken per clock while no result is held up; a request waits in an input
// register, is stepped through the sequencer into a result register once the
// output can advance, and its result is offered from that register. While a
// result waits, the input register still takes one more request; after that
// the input stalls until the result leaves.
// Configuration sits behind the APB port at byte addresses 0, 4, 8 and 12.
module i2c_register_master_unit #(
  parameter int unsigned MAX_BLOCK = i2crm_pkg::MAX_BLOCK_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  i2crm_pkg::in_item_t               in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output i2crm_pkg::out_item_t              out_data_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [i2crm_pkg::APB_AW-1:0]      paddr,
  input  logic [i2crm_pkg::APB_DW-1:0]      pwdata,
  output logic [i2crm_pkg::APB_DW-1:0]      prdata,
  output logic                              pready
);
  import i2crm_pkg::*;

  cfg_t      cfg_q;
  in_item_t  in_q;
  logic      in_vld_q;
  out_item_t out_q;
  logic      out_vld_q;
  out_item_t res;
  logic      advance;
  logic      step;
  logic      cfg_wr;

  assign advance    = !out_vld_q || out_ready_i;
  assign step       = advance && in_vld_q;
  assign in_ready_o = !in_vld_q || advance;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[3:2])
      REG_DEV_ADDR:  prdata = APB_DW'(cfg_q.device_address);
      REG_QTR_TICKS: prdata = APB_DW'(cfg_q.quarter_period_ticks);
      REG_ACK_TMO:   prdata = APB_DW'(cfg_q.ack_timeout);
      REG_ATT_LIMIT: prdata = APB_DW'(cfg_q.attempt_limit);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_address       <= DEV_ADDR_RST;
      cfg_q.quarter_period_ticks <= QTR_TICKS_RST;
      cfg_q.ack_timeout          <= ACK_TMO_RST;
      cfg_q.attempt_limit        <= ATT_LIMIT_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_DEV_ADDR:  cfg_q.device_address <= pwdata[6:0];
        REG_QTR_TICKS: cfg_q.quarter_period_ticks <= pwdata[15:0];
        REG_ACK_TMO:   cfg_q.ack_timeout <= pwdata[7:0];
        REG_ATT_LIMIT: cfg_q.attempt_limit <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  i2crm_core #(
    .MAX_BLOCK(MAX_BLOCK)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (step) begin
      out_q <= res;
    end
  end

endmodule

/* hdl/i2crm_checker.sv */
// ----------------------------------------------------------------------------
// i2crm_checker
// Port-level checks of the I2C register master, bound to the top level.
// ----------------------------------------------------------------------------
module i2crm_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input i2crm_pkg::out_item_t out_data_o
);
  import i2crm_pkg::*;

  a_status_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status |-> out_data_o.done_res)
    else $error("status without done");

  a_last_on_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last |-> out_data_o.rd_valid)
    else $error("last without read byte");

  a_byte_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.rd_valid |-> out_data_o.busy_res && !out_data_o.done_res)
    else $error("read byte outside a transaction");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_res |-> !out_data_o.busy_res)
    else $error("done while still busy");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind i2c_register_master_unit i2crm_checker u_i2crm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

/* tb/sv/i2crm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crm_tb_checker
// Predicts and checks every result of the I2C register master.
// Tracks the APB register writes, steps its own copy of the bus sequencer
// once per accepted request, and compares each accepted result field by
// field with the oldest prediction.
// ----------------------------------------------------------------------------
module i2crm_tb_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  i2crm_pkg::in_item_t          in_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  i2crm_pkg::out_item_t         out_data_i,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic                         pready_i,
  input  logic [i2crm_pkg::APB_AW-1:0] paddr_i,
  input  logic [i2crm_pkg::APB_DW-1:0] pwdata_i,
  output int                           fail_count_o,
  output int                           pending_o,
  output logic                         busy_o
);
  import i2crm_pkg::*;

  logic [6:0]  dev_addr;
  logic [15:0] qtr_ticks;
  logic [7:0]  ack_tmo;
  logic [3:0]  att_limit;

  phase_e      phase;
  logic [15:0] tick_div;
  logic [3:0]  bit_idx;
  logic [6:0]  byte_idx;
  logic [7:0]  shift_byte;
  logic [7:0]  ack_wait;
  logic [3:0]  attempts;
  logic [1:0]  kind;
  logic [7:0]  held_reg;
  logic [7:0]  held_data;
  logic [5:0]  held_count;
  int unsigned quarter;
  int unsigned hdr_step;
  logic        failed;

  out_item_t   expected_bus[$];
  int          errors = 0;
  int          result_no = 0;

  assign fail_count_o = errors;

  function automatic logic quarter_end();
    logic [15:0] q;
    q = (qtr_ticks == 16'd0) ? 16'd1 : qtr_ticks;
    tick_div = tick_div + 16'd1;
    if (tick_div >= q || tick_div == 16'd0) begin
      tick_div = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void enter(phase_e ph);
    phase = ph;
    quarter = 0;
    tick_div = '0;
  endfunction

  function automatic void load_tx(logic [7:0] b);
    shift_byte = b;
    bit_idx = '0;
    enter(PH_TX);
  endfunction

  function automatic logic last_bus_byte();
    if (kind != FUNC_BLOCK) return 1'b1;
    return int'(byte_idx) == 2 * int'(held_count) - 1;
  endfunction

  function automatic void after_ack(logic nack);
    if (nack && kind == FUNC_WRITE) begin
      failed = 1'b1;
      enter(PH_STOP);
      return;
    end
    hdr_step++;
    if (hdr_step == 1) begin
      load_tx(held_reg);
    end else if (kind == FUNC_WRITE) begin
      if (hdr_step == 2) load_tx(held_data);
      else enter(PH_STOP);
    end else if (hdr_step == 2) begin
      enter(PH_RSTART);
    end else begin
      byte_idx = '0;
      bit_idx = '0;
      shift_byte = '0;
      enter(PH_RX);
    end
  endfunction

  // one bus tick; pins reflect the state before the step
  function automatic out_item_t bus_step(in_item_t it);
    out_item_t  r;
    logic [5:0] n;
    r = '0;
    case (phase)
      PH_START: begin
        r.scl_low = (quarter == 3);
        r.sda_low = (quarter >= 2);
      end
      PH_RSTART: r.scl_low = 1'b1;
      PH_TX: begin
        r.scl_low = (quarter < 2);
        r.sda_low = ~shift_byte[7];
      end
      PH_ACK_LOW: r.scl_low = 1'b1;
      PH_RX: r.scl_low = (quarter < 2);
      PH_MACK: begin
        r.scl_low = (quarter < 2);
        r.sda_low = ~last_bus_byte();
      end
      PH_STOP: begin
        r.scl_low = (quarter == 0);
        r.sda_low = (quarter < 2);
      end
      default: ;
    endcase

    case (phase)
      PH_IDLE: begin
        if (it.func != FUNC_TICK) begin
          n = it.byte_count;
          if (n == 6'd0) n = 6'd1;
          if (n > MAX_BLOCK_DEF) n = 6'(MAX_BLOCK_DEF);
          kind = it.func;
          held_reg = it.reg_addr;
          held_data = it.wr_data;
          held_count = n;
          attempts = '0;
          failed = 1'b0;
          hdr_step = 0;
          enter(PH_START);
        end
      end
      PH_START: begin
        if (quarter_end()) begin
          quarter++;
          if (quarter >= 4) begin
            if (hdr_step == 0) load_tx({dev_addr, 1'b0});
            else load_tx({dev_addr, 1'b1});
          end
        end
      end
      PH_RSTART: begin
        if (quarter_end()) enter(PH_START);
      end
      PH_TX: begin
        if (quarter_end()) begin
          quarter++;
          if (quarter >= 4) begin
            quarter = 0;
            shift_byte = {shift_byte[6:0], 1'b0};
            bit_idx++;
            if (bit_idx >= 4'd8) enter(PH_ACK_LOW);
          end
        end
      end
      PH_ACK_LOW: begin
        if (quarter_end()) begin
          quarter++;
          if (quarter >= 2) begin
            ack_wait = '0;
            enter(PH_ACK_WAIT);
          end
        end
      end
      PH_ACK_WAIT: begin
        if (!it.sda_in) begin
          enter(PH_ACK_OK);
        end else begin
          if (ack_wait < 8'd255) ack_wait++;
          if (ack_wait >= ack_tmo) enter(PH_ACK_NACK);
        end
      end
      PH_ACK_OK, PH_ACK_NACK: begin
        if (quarter_end()) after_ack(phase == PH_ACK_NACK);
      end
      PH_RX: begin
        if (quarter_end()) begin
          if (quarter == 2) shift_byte = {shift_byte[6:0], it.sda_in};
          quarter++;
          if (quarter >= 4) begin
            quarter = 0;
            bit_idx++;
            if (bit_idx >= 4'd8) begin
              if (kind != FUNC_BLOCK) begin
                r.rd_valid = 1'b1;
                r.last = 1'b1;
                r.rd_data = shift_byte;
              end else if (!byte_idx[0]) begin
                // only the first byte of each pair goes out
                r.rd_valid = 1'b1;
                r.rd_data = shift_byte;
                r.last = (int'(byte_idx) == 2 * int'(held_count) - 2);
              end
              enter(PH_MACK);
            end
          end
        end
      end
      PH_MACK: begin
        if (quarter_end()) begin
          quarter++;
          if (quarter >= 4) begin
            if (last_bus_byte()) begin
              enter(PH_STOP);
            end else begin
              byte_idx++;
              bit_idx = '0;
              shift_byte = '0;
              enter(PH_RX);
            end
          end
        end
      end
      PH_STOP: begin
        if (quarter_end()) begin
          quarter++;
          if (quarter >= 4) begin
            if (failed) begin
              attempts++;
              if (attempts >= att_limit) begin
                enter(PH_IDLE);
                r.done_res = 1'b1;
                r.status = 1'b1;
              end else begin
                failed = 1'b0;
                hdr_step = 0;
                enter(PH_START);
              end
            end else begin
              enter(PH_IDLE);
              r.done_res = 1'b1;
            end
          end
        end
      end
      default: enter(PH_IDLE);
    endcase
    r.busy_res = (phase != PH_IDLE);
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: result %0d %s expected %0h got %0h", $time, result_no, name, want, got);
    end
  endtask

  task automatic compare_result(input out_item_t want, input out_item_t got);
    result_no++;
    check_field("scl_low", want.scl_low, got.scl_low);
    check_field("sda_low", want.sda_low, got.sda_low);
    check_field("rd_data", want.rd_data, got.rd_data);
    check_field("rd_valid", want.rd_valid, got.rd_valid);
    check_field("last", want.last, got.last);
    check_field("busy_res", want.busy_res, got.busy_res);
    check_field("done_res", want.done_res, got.done_res);
    check_field("status", want.status, got.status);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr = DEV_ADDR_RST;
      qtr_ticks = QTR_TICKS_RST;
      ack_tmo = ACK_TMO_RST;
      att_limit = ATT_LIMIT_RST;
      phase = PH_IDLE;
      tick_div = '0;
      bit_idx = '0;
      byte_idx = '0;
      shift_byte = '0;
      ack_wait = '0;
      attempts = '0;
      kind = '0;
      held_reg = '0;
      held_data = '0;
      held_count = '0;
      quarter = 0;
      hdr_step = 0;
      failed = 1'b0;
      expected_bus.delete();
      pending_o <= 0;
      busy_o <= 1'b0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[3:2])
          REG_DEV_ADDR: dev_addr = pwdata_i[6:0];
          REG_QTR_TICKS: qtr_ticks = pwdata_i[15:0];
          REG_ACK_TMO: ack_tmo = pwdata_i[7:0];
          REG_ATT_LIMIT: att_limit = pwdata_i[3:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_bus.size() == 0) begin
          errors++;
          result_no++;
          $display("%0t: result %0d expected none got %0h", $time, result_no, out_data_i);
        end else begin
          compare_result(expected_bus.pop_front(), out_data_i);
        end
      end
      if (in_valid_i && in_ready_i) expected_bus.push_back(bus_step(in_data_i));
      pending_o <= expected_bus.size();
      busy_o <= (phase != PH_IDLE);
    end
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the I2C register master.
// Runs directed register writes, reads and block reads at the register
// extremes, then random transactions under random register settings, with
// random request gaps and result stalls; the checker does the comparison.
// ----------------------------------------------------------------------------
module tb;
  import i2crm_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int ITEM_TARGET = 1900;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int   fail_count;
  int   pending;
  logic bus_busy;

  bit   calm = 1'b0;
  int   item_count = 0;
  int   stuck = 0;
  int   hold = 0;

  i2c_register_master_unit uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  i2crm_tb_checker chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .busy_o      (bus_busy)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // mostly short, now and then long
  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 60) : $urandom_range(1, 3);
  endfunction

  function automatic logic sda_level(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  always @(posedge clk) begin
    if (hold > 0) begin
      hold <= hold - 1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      hold <= gap_len() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_item(input in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    item_count++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat (gap_len()) @(posedge clk);
    end
  endtask

  task automatic send_tick(input logic [1:0] f, input int pct);
    in_item_t it;
    it.func = f;
    it.reg_addr = 8'($urandom);
    it.wr_data = 8'($urandom);
    it.byte_count = 6'($urandom_range(0, 63));
    it.sda_in = sda_level(pct);
    send_item(it);
  endtask

  // request, then bus ticks until the sequencer is idle again;
  // some ticks carry requests that must be ignored while busy
  task automatic run_request(input logic [1:0] f, input logic [7:0] ra, input logic [7:0] wd,
                             input logic [5:0] cnt, input int pct);
    in_item_t it;
    it = '{func: f, reg_addr: ra, wr_data: wd, byte_count: cnt, sda_in: sda_level(pct)};
    send_item(it);
    send_tick(FUNC_TICK, pct);
    while (bus_busy)
      send_tick(($urandom_range(0, 7) == 0) ? 2'($urandom_range(1, 3)) : FUNC_TICK, pct);
    send_tick(FUNC_TICK, pct);
    send_tick(FUNC_TICK, pct);
    while (bus_busy) send_tick(FUNC_TICK, pct);
  endtask

  task automatic quiesce();
    while (bus_busy) send_tick(FUNC_TICK, 50);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input int dev, input int q, input int tmo, input int lim);
    quiesce();
    apb_write(REG_DEV_ADDR, dev);
    apb_write(REG_QTR_TICKS, q);
    apb_write(REG_ACK_TMO, tmo);
    apb_write(REG_ATT_LIMIT, lim);
  endtask

  initial begin : stimulus
    int         ntx;
    int         tmo;
    int         pct;
    logic [1:0] f;
    logic [5:0] cnt;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle ticks, then a clean write with the reset address, timeout and limit
    repeat (5) send_tick(FUNC_TICK, 50);
    quiesce();
    apb_write(REG_QTR_TICKS, 1);
    run_request(FUNC_WRITE, 8'h00, 8'h00, 6'd1, 10);

    // target never acknowledges: the only attempt times out
    set_config(127, 1, 255, 1);
    run_request(FUNC_WRITE, 8'hFF, 8'hFF, 6'd63, 100);

    // zero period, zero timeout, zero attempt limit
    set_config(0, 0, 0, 0);
    run_request(FUNC_WRITE, 8'h01, 8'h02, 6'd1, 100);
    run_request(FUNC_READ, 8'h03, 8'h04, 6'd1, 100);
    run_request(FUNC_BLOCK, 8'h00, 8'hFF, 6'd0, 0);

    set_config(7'h55, 16'hFFFF, 1, 1);
    repeat (20) send_tick(FUNC_TICK, 50);

    while (item_count < ITEM_TARGET) begin
      case ($urandom_range(0, 3))
        0: tmo = $urandom_range(0, 2);
        1: tmo = $urandom_range(3, 10);
        default: tmo = $urandom_range(11, 30);
      endcase
      set_config($urandom_range(0, 127), $urandom_range(0, 3), tmo, $urandom_range(0, 15));
      calm <= ($urandom_range(0, 3) == 0);
      ntx = $urandom_range(2, 6);
      while (ntx > 0 && item_count < ITEM_TARGET) begin
        ntx--;
        repeat ($urandom_range(0, 5)) send_tick(FUNC_TICK, 50);
        case ($urandom_range(0, 9))
          0, 1, 2, 3: f = FUNC_WRITE;
          4, 5, 6: f = FUNC_READ;
          default: f = FUNC_BLOCK;
        endcase
        cnt = 6'($urandom_range(0, 4));
        case ($urandom_range(0, 7))
          5, 6: pct = 10;
          7: pct = (f == FUNC_WRITE) ? 50 : 97;
          default: pct = 30;
        endcase
        run_request(f, 8'($urandom), 8'($urandom), cnt, pct);
      end
    end

    calm <= 1'b0;
    quiesce();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/i2crm_pkg.sv
hdl/i2crm_core.sv
hdl/i2c_register_master_unit.sv
hdl/i2crm_checker.sv
tb/sv/i2crm_checker.sv
tb/sv/tb.sv
